### rtl/core/dyadic_tree_cross_sum_accumulator_assert.svh
// Assertion macros used by the back end of the cross-sum accumulator RTL.
`ifndef DYADIC_TREE_CROSS_SUM_ACCUMULATOR_ASSERT_SVH
`define DYADIC_TREE_CROSS_SUM_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DTCSA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define DTCSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define DTCSA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define DTCSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/core/dtcsa_pkg.sv
// Shared types, constants and helper functions of the cross-sum accumulator.
`default_nettype none
package dtcsa_pkg;

   localparam int TREE_LEVELS = 10;
   localparam int TREE_SLOTS  = 2048;
   localparam int SLOT_W      = $clog2(TREE_SLOTS);
   localparam int POS_W       = (TREE_LEVELS + 2 > SLOT_W + 1) ? TREE_LEVELS + 2 : SLOT_W + 1;
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

   localparam int RANK_W  = 11;
   localparam int CNT_W   = 11;
   localparam int X_W     = 32;
   localparam int XY_W    = 48;
   localparam int SUM_W   = 48;
   localparam int TREE_W  = 64;
   localparam int OUT_W   = 64;
   localparam int EPOCH_W = 8;

   localparam int PRE_W    = 51;
   localparam int G1P_W    = 15;
   localparam int CNTSUM_W = CNT_W + $clog2(TREE_LEVELS + 1);
   localparam int G1_W     = CNTSUM_W + 4;
   localparam int GSUM_W   = TREE_W + 3;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = 98;
   localparam int FIN_W    = ACC_W - 16 + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CSR_ITEM_COUNT,
      CSR_TOTAL_X,
      CSR_TOTAL_Y,
      CSR_TOTAL_XY
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } back_state_type;

   // One classified sample as handed from the front to the back
   typedef struct packed {
      logic [RANK_W-1:0]        rank;
      logic                     ins_en;
      logic [RANK_W-1:0]        prev_rank;
      logic signed [X_W-1:0]    prev_x;
      logic signed [X_W-1:0]    prev_y;
      logic signed [XY_W-1:0]   prev_xy;
      logic signed [X_W-1:0]    x;
      logic signed [X_W-1:0]    y;
      logic signed [PRE_W-1:0]  pre_x;
      logic signed [PRE_W-1:0]  pre_y;
      logic signed [PRE_W-1:0]  pre_xy;
      logic signed [G1P_W-1:0]  g1_pre;
      logic                     last;
   } work_type;

   // One slot of the four partial-sum trees, tagged with the set epoch
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [CNT_W-1:0]   cnt;
      logic [TREE_W-1:0]  sx;
      logic [TREE_W-1:0]  sy;
      logic [TREE_W-1:0]  sxy;
   } tree_word_type;

   // First slot of a tree level
   function automatic logic [POS_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
      return (POS_W'(1) << (TREE_LEVELS + 1)) - (POS_W'(1) << (TREE_LEVELS + 1 - int'(lvl)));
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_gamma(input logic signed [GSUM_W-1:0] v);
      if (&v[GSUM_W-1:OUT_W-1] || ~|v[GSUM_W-1:OUT_W-1]) begin
         return v[OUT_W-1:0];
      end
      return v[GSUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_sum(input logic signed [FIN_W-1:0] v);
      if (&v[FIN_W-1:OUT_W-1] || ~|v[FIN_W-1:OUT_W-1]) begin
         return v[OUT_W-1:0];
      end
      return v[FIN_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
   endfunction

endpackage
`default_nettype wire

### rtl/core/dtcsa_front.sv
// Front end: configuration registers, sample intake and per-sample precompute.
`default_nettype none
module dtcsa_front import dtcsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [SUM_W-1:0]         csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RANK_W-1:0]        req_rank_y,
   input  logic signed [X_W-1:0]    req_x,
   input  logic signed [X_W-1:0]    req_y,
   input  logic signed [XY_W-1:0]   req_xy,
   input  logic signed [SUM_W-1:0]  req_sx_x,
   input  logic signed [SUM_W-1:0]  req_sx_y,
   input  logic signed [SUM_W-1:0]  req_sx_xy,
   input  logic signed [SUM_W-1:0]  req_sy_x,
   input  logic signed [SUM_W-1:0]  req_sy_y,
   input  logic signed [SUM_W-1:0]  req_sy_xy,
   input  logic                     req_last,
   input  logic                     q_full,
   output logic                     q_push,
   output work_type                 q_push_data
);

   logic [RANK_W-1:0]       item_count_ff, item_count_in;
   logic signed [SUM_W-1:0] total_x_ff, total_x_in;
   logic signed [SUM_W-1:0] total_y_ff, total_y_in;
   logic signed [SUM_W-1:0] total_xy_ff, total_xy_in;
   logic [RANK_W-1:0]       item_index_ff, item_index_in;
   logic [RANK_W-1:0]       prev_rank_ff, prev_rank_in;
   logic signed [X_W-1:0]   prev_x_ff, prev_x_in;
   logic signed [X_W-1:0]   prev_y_ff, prev_y_in;
   logic signed [XY_W-1:0]  prev_xy_ff, prev_xy_in;
   logic signed [G1P_W-1:0] n_s, r_s, i_s;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Decode register writes
   always_comb begin
      item_count_in = item_count_ff;
      total_x_in    = total_x_ff;
      total_y_in    = total_y_ff;
      total_xy_in   = total_xy_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ITEM_COUNT: item_count_in = csr_data[RANK_W-1:0];
            CSR_TOTAL_X:    total_x_in    = csr_data;
            CSR_TOTAL_Y:    total_y_in    = csr_data;
            CSR_TOTAL_XY:   total_xy_in   = csr_data;
            default:        item_count_in = item_count_ff;
         endcase
      end
   end

   // Track position in the set and the previous sample
   always_comb begin
      item_index_in = item_index_ff;
      prev_rank_in  = prev_rank_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_xy_in    = prev_xy_ff;
      if (q_push) begin
         if (req_last) begin
            item_index_in = '0;
            prev_rank_in  = '0;
            prev_x_in     = '0;
            prev_y_in     = '0;
            prev_xy_in    = '0;
         end else begin
            item_index_in = item_index_ff + RANK_W'(1);
            prev_rank_in  = req_rank_y;
            prev_x_in     = req_x;
            prev_y_in     = req_y;
            prev_xy_in    = req_xy;
         end
      end
   end

   // Form the tree-independent parts of the four gamma terms
   always_comb begin
      n_s = signed'(G1P_W'(item_count_ff));
      r_s = signed'(G1P_W'(req_rank_y));
      i_s = signed'(G1P_W'(item_index_ff));
      q_push_data.rank      = req_rank_y;
      q_push_data.ins_en    = (item_index_ff != '0);
      q_push_data.prev_rank = prev_rank_ff;
      q_push_data.prev_x    = prev_x_ff;
      q_push_data.prev_y    = prev_y_ff;
      q_push_data.prev_xy   = prev_xy_ff;
      q_push_data.x         = req_x;
      q_push_data.y         = req_y;
      q_push_data.pre_x  = PRE_W'(total_x_ff) - PRE_W'(req_x)
                           - (PRE_W'(req_sy_x) <<< 1) - (PRE_W'(req_sx_x) <<< 1);
      q_push_data.pre_y  = PRE_W'(total_y_ff) - PRE_W'(req_y)
                           - (PRE_W'(req_sy_y) <<< 1) - (PRE_W'(req_sx_y) <<< 1);
      q_push_data.pre_xy = PRE_W'(total_xy_ff) - PRE_W'(req_xy)
                           - (PRE_W'(req_sy_xy) <<< 1) - (PRE_W'(req_sx_xy) <<< 1);
      q_push_data.g1_pre = n_s - G1P_W'(1) - (r_s <<< 1) - ((i_s + G1P_W'(1)) <<< 1);
      q_push_data.last   = req_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= RANK_W'(1);
         total_x_ff    <= '0;
         total_y_ff    <= '0;
         total_xy_ff   <= '0;
         item_index_ff <= '0;
         prev_rank_ff  <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_xy_ff    <= '0;
      end else begin
         item_count_ff <= item_count_in;
         total_x_ff    <= total_x_in;
         total_y_ff    <= total_y_in;
         total_xy_ff   <= total_xy_in;
         item_index_ff <= item_index_in;
         prev_rank_ff  <= prev_rank_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_xy_ff    <= prev_xy_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/dtcsa_fifo.sv
// Short queue of classified samples between front and back.
`default_nettype none
module dtcsa_fifo import dtcsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output work_type pop_data,
   output logic     full,
   output logic     empty
);

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/dtcsa_back.sv
// Back end: tree memory sequencer, gamma forming and cross-term accumulation.
`default_nettype none
`include "dyadic_tree_cross_sum_accumulator_assert.svh"
module dtcsa_back import dtcsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  work_type                q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_cross_sum
);

   localparam int QRD_STEP = TREE_LEVELS + 1;
   localparam int GAM_STEP = 2 * TREE_LEVELS + 2;
   localparam int MUL_STEP = GAM_STEP + 1;
   localparam int MUL_OPS  = 7;
   localparam int FIN_STEP = MUL_STEP + MUL_OPS + 1;
   localparam int STEP_W   = $clog2(FIN_STEP + 1);

   tree_word_type tree_mem [TREE_SLOTS];
   tree_word_type mem_rdata_ff;
   tree_word_type mem_wdata;
   logic [SLOT_W-1:0] mem_waddr, mem_raddr;
   logic              mem_we;

   back_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SLOT_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   work_type           work_ff, work_in;

   logic [CNTSUM_W-1:0]      q_cnt_ff, q_cnt_in;
   logic signed [TREE_W-1:0] q_x_ff, q_x_in, q_y_ff, q_y_in, q_xy_ff, q_xy_in;
   logic signed [G1_W-1:0]   g1_ff, g1_in;
   logic signed [OUT_W-1:0]  gx_ff, gx_in, gy_ff, gy_in, gxy_ff, gxy_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     add_ff, add_in, neg_ff, neg_in, sh_ff, sh_in;
   logic signed [OUT_W-1:0]  xy_ff, xy_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, term;
   logic signed [OUT_W-1:0]  running_ff, running_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic ins_rd, ins_wr, q_acc, gam, mul, fin, hold, fin_fire, epoch_wrap;
   logic [LVL_W-1:0]  lvl_a, lvl_b, lvl_c, lvl_d;
   logic [TREE_LEVELS-1:0] k_ins, k_q;
   logic [POS_W-1:0]  pos_a, pos_b, pos_c, pos_d, kk_d;
   logic              rd_live;
   logic [2:0]        op;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [FIN_W-1:0] fin_sum;

   // Decode the step counter into phases and tree levels
   always_comb begin
      ins_rd = (state_ff == ST_RUN) && (step_ff < STEP_W'(TREE_LEVELS));
      ins_wr = (state_ff == ST_RUN) && (step_ff >= STEP_W'(1))
               && (step_ff <= STEP_W'(TREE_LEVELS));
      q_acc  = (state_ff == ST_RUN) && (step_ff >= STEP_W'(QRD_STEP + 1))
               && (step_ff <= STEP_W'(QRD_STEP + TREE_LEVELS));
      gam    = (state_ff == ST_RUN) && (step_ff == STEP_W'(GAM_STEP));
      mul    = (state_ff == ST_RUN) && (step_ff >= STEP_W'(MUL_STEP))
               && (step_ff < STEP_W'(MUL_STEP + MUL_OPS));
      fin    = (state_ff == ST_RUN) && (step_ff == STEP_W'(FIN_STEP));
      lvl_a  = LVL_W'(step_ff);
      lvl_b  = LVL_W'(step_ff - STEP_W'(1));
      lvl_c  = LVL_W'(step_ff - STEP_W'(QRD_STEP));
      lvl_d  = LVL_W'(step_ff - STEP_W'(QRD_STEP + 1));
      op     = 3'(step_ff - STEP_W'(MUL_STEP));
      k_ins  = TREE_LEVELS'(work_ff.prev_rank - RANK_W'(1));
      k_q    = TREE_LEVELS'(work_ff.rank - RANK_W'(1));
      pos_a  = level_base(lvl_a) + (POS_W'(k_ins) >> lvl_a);
      pos_b  = level_base(lvl_b) + (POS_W'(k_ins) >> lvl_b);
      pos_c  = level_base(lvl_c) + ((POS_W'(k_q) >> lvl_c) & ~POS_W'(1));
      kk_d   = POS_W'(k_q) >> lvl_d;
      pos_d  = level_base(lvl_d) + (kk_d & ~POS_W'(1));
      hold   = work_ff.last && rsp_valid_ff && rsp_stall;
      fin_fire   = fin && !hold;
      epoch_wrap = (epoch_ff == {EPOCH_W{1'b1}});
      rd_live    = (mem_rdata_ff.epoch == epoch_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == SLOT_W'(TREE_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_empty) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (fin_fire) state_in = (work_ff.last && epoch_wrap) ? ST_CLEAR : ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory port and queue controls
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ptr_ff;
      mem_wdata = '0;
      mem_wdata.epoch = epoch_ff;
      mem_raddr = ins_rd ? pos_a[SLOT_W-1:0] : pos_c[SLOT_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            q_pop = !q_empty;
         end
         ST_RUN: begin
            mem_waddr = pos_b[SLOT_W-1:0];
            mem_we    = ins_wr && work_ff.ins_en && (pos_b < POS_W'(TREE_SLOTS));
            mem_wdata.cnt = (rd_live ? mem_rdata_ff.cnt : '0) + CNT_W'(1);
            mem_wdata.sx  = (rd_live ? mem_rdata_ff.sx : '0) + TREE_W'(work_ff.prev_x);
            mem_wdata.sy  = (rd_live ? mem_rdata_ff.sy : '0) + TREE_W'(work_ff.prev_y);
            mem_wdata.sxy = (rd_live ? mem_rdata_ff.sxy : '0) + TREE_W'(work_ff.prev_xy);
         end
         default: q_pop = 1'b0;
      endcase
   end

   // Select multiplier operands for each partial product
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      neg_in = 1'b0;
      sh_in  = 1'b0;
      case (op)
         3'd0: begin
            mul_a = MUL_W'(work_ff.x);
            mul_b = MUL_W'(work_ff.y);
         end
         3'd1: begin
            mul_a = signed'({1'b0, prod_ff[31:0]});
            mul_b = MUL_W'(g1_ff);
         end
         3'd2: begin
            mul_a = MUL_W'(signed'(xy_ff[63:32]));
            mul_b = MUL_W'(g1_ff);
            sh_in = 1'b1;
         end
         3'd3: begin
            mul_a  = MUL_W'(work_ff.x);
            mul_b  = signed'({1'b0, gy_ff[31:0]});
            neg_in = 1'b1;
         end
         3'd4: begin
            mul_a  = MUL_W'(work_ff.x);
            mul_b  = MUL_W'(signed'(gy_ff[63:32]));
            neg_in = 1'b1;
            sh_in  = 1'b1;
         end
         3'd5: begin
            mul_a  = MUL_W'(work_ff.y);
            mul_b  = signed'({1'b0, gx_ff[31:0]});
            neg_in = 1'b1;
         end
         3'd6: begin
            mul_a  = MUL_W'(work_ff.y);
            mul_b  = MUL_W'(signed'(gx_ff[63:32]));
            neg_in = 1'b1;
            sh_in  = 1'b1;
         end
         default: mul_a = '0;
      endcase
      prod_in = mul_a * mul_b;
      add_in  = mul && (op != 3'd0);
   end

   // Datapath next values
   always_comb begin
      work_in    = q_pop ? q_data : work_ff;
      step_in    = q_pop ? '0 : ((state_ff == ST_RUN && !fin) ? step_ff + STEP_W'(1) : step_ff);
      clr_ptr_in = (state_ff == ST_CLEAR) ? clr_ptr_ff + SLOT_W'(1) : '0;
      epoch_in   = (fin_fire && work_ff.last) ? epoch_ff + EPOCH_W'(1) : epoch_ff;

      // Sum the query levels whose bit is set
      q_cnt_in = q_cnt_ff;
      q_x_in   = q_x_ff;
      q_y_in   = q_y_ff;
      q_xy_in  = q_xy_ff;
      if (q_pop) begin
         q_cnt_in = '0;
         q_x_in   = '0;
         q_y_in   = '0;
         q_xy_in  = '0;
      end else if (q_acc && kk_d[0] && (pos_d < POS_W'(TREE_SLOTS)) && rd_live) begin
         q_cnt_in = q_cnt_ff + CNTSUM_W'(mem_rdata_ff.cnt);
         q_x_in   = q_x_ff + mem_rdata_ff.sx;
         q_y_in   = q_y_ff + mem_rdata_ff.sy;
         q_xy_in  = q_xy_ff + mem_rdata_ff.sxy;
      end

      // Form the gamma terms
      g1_in  = g1_ff;
      gx_in  = gx_ff;
      gy_in  = gy_ff;
      gxy_in = gxy_ff;
      if (gam) begin
         g1_in  = (G1_W'(q_cnt_ff) << 2) + G1_W'(work_ff.g1_pre);
         gx_in  = sat_gamma((GSUM_W'(q_x_ff) <<< 2) + GSUM_W'(work_ff.pre_x));
         gy_in  = sat_gamma((GSUM_W'(q_y_ff) <<< 2) + GSUM_W'(work_ff.pre_y));
         gxy_in = sat_gamma((GSUM_W'(q_xy_ff) <<< 2) + GSUM_W'(work_ff.pre_xy));
      end

      // Keep x times y for its upper partial product
      xy_in = (step_ff == STEP_W'(MUL_STEP + 1)) ? prod_ff[OUT_W-1:0] : xy_ff;

      // Accumulate the partial products
      term = sh_ff ? (ACC_W'(prod_ff) <<< 32) : ACC_W'(prod_ff);
      if (mul && op == 3'd0) begin
         acc_in = ACC_W'(gxy_ff) <<< 16;
      end else if (add_ff) begin
         acc_in = neg_ff ? acc_ff - term : acc_ff + term;
      end else begin
         acc_in = acc_ff;
      end

      // Fold into the running sum and emit on the last sample
      fin_sum      = FIN_W'(running_ff) + FIN_W'(acc_ff >>> 16);
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      if (fin_fire) begin
         running_in = work_ff.last ? '0 : sat_sum(fin_sum);
         if (work_ff.last) begin
            rsp_valid_in = 1'b1;
            rsp_sum_in   = sat_sum(fin_sum);
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cross_sum = rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_ptr_ff   <= '0;
         epoch_ff     <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         add_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ptr_ff   <= clr_ptr_in;
         epoch_ff     <= epoch_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         add_ff       <= add_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      q_cnt_ff   <= q_cnt_in;
      q_x_ff     <= q_x_in;
      q_y_ff     <= q_y_in;
      q_xy_ff    <= q_xy_in;
      g1_ff      <= g1_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      gxy_ff     <= gxy_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      sh_ff      <= sh_in;
      xy_ff      <= xy_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   // Tree memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= tree_mem[mem_raddr];
   end

   `DTCSA_ASSERT_IMPLY(a_no_pop_in_clear, clock, reset, state_ff == ST_CLEAR, !q_pop)
   `DTCSA_ASSERT_IMPLY(a_rmw_no_overlap, clock, reset, mem_we && ins_rd, mem_waddr != mem_raddr)
   `DTCSA_ASSERT_NEXT(a_last_emits, clock, reset, fin_fire && work_ff.last, rsp_valid_ff)
   `DTCSA_ASSERT_IMPLY(a_step_range, clock, reset, state_ff == ST_RUN, step_ff <= STEP_W'(FIN_STEP))

endmodule
`default_nettype wire

### rtl/core/dyadic_tree_cross_sum_accumulator.sv
// Top level of the dyadic-tree cross-sum accumulator.
`default_nettype none
// Samples enter in x order; each is queued, popped by the back end and then
// processed, and the back end pops no new sample before the current one is done.
// A set's result is registered once the fold of its final sample is done. Each
// sample takes ten read-modify-write inserts and ten queries on the single write /
// single read port of the tree memory (each through the registered read), the
// gamma step, seven partial products through one shared 33x33 multiplier, then
// the addition of the last product and the final fold. Up to two samples may wait
// in the queue while one is processed. A result waiting on rsp_stall holds the back
// end only once the next set's final sample is ready to emit; the queue then fills
// and req_stall rises. After reset, and after every 256th completed set, the tree
// memory is swept clear, during which no sample is started (configuration writes
// are still taken).
module dyadic_tree_cross_sum_accumulator import dtcsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [SUM_W-1:0]         csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RANK_W-1:0]        req_rank_y,
   input  logic signed [X_W-1:0]    req_x,
   input  logic signed [X_W-1:0]    req_y,
   input  logic signed [XY_W-1:0]   req_xy,
   input  logic signed [SUM_W-1:0]  req_sx_x,
   input  logic signed [SUM_W-1:0]  req_sx_y,
   input  logic signed [SUM_W-1:0]  req_sx_xy,
   input  logic signed [SUM_W-1:0]  req_sy_x,
   input  logic signed [SUM_W-1:0]  req_sy_y,
   input  logic signed [SUM_W-1:0]  req_sy_xy,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_cross_sum
);

   work_type q_push_data, q_pop_data;
   logic     q_push, q_pop, q_full, q_empty;

   dtcsa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rank_y  (req_rank_y),
      .req_x       (req_x),
      .req_y       (req_y),
      .req_xy      (req_xy),
      .req_sx_x    (req_sx_x),
      .req_sx_y    (req_sx_y),
      .req_sx_xy   (req_sx_xy),
      .req_sy_x    (req_sy_x),
      .req_sy_y    (req_sy_y),
      .req_sy_xy   (req_sy_xy),
      .req_last    (req_last),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   dtcsa_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   dtcsa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cross_sum (rsp_cross_sum)
   );

endmodule
`default_nettype wire

### bench/tb_dyadic_tree_cross_sum_accumulator.sv
// Self-checking testbench for the dyadic-tree cross-sum accumulator.
`timescale 1ns / 1ps
module tb_dyadic_tree_cross_sum_accumulator;
   import dtcsa_pkg::*;

   typedef struct packed {
      logic [RANK_W-1:0]        rank;
      logic signed [X_W-1:0]    x;
      logic signed [X_W-1:0]    y;
      logic signed [XY_W-1:0]   xy;
      logic signed [SUM_W-1:0]  sx_x;
      logic signed [SUM_W-1:0]  sx_y;
      logic signed [SUM_W-1:0]  sx_xy;
      logic signed [SUM_W-1:0]  sy_x;
      logic signed [SUM_W-1:0]  sy_y;
      logic signed [SUM_W-1:0]  sy_xy;
      logic                     last;
   } sample_type;

   typedef logic signed [127:0] wide_type;

   localparam longint MAX48 = 64'sh00007FFFFFFFFFFF;
   localparam longint MIN48 = -64'sh0000800000000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_ITEM_COUNT;
   logic [SUM_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type drv = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_cross_sum;

   // Register shadow and predictor state
   logic [CNT_W-1:0]        n_reg = 11'd1;
   logic signed [SUM_W-1:0] tot_x = '0, tot_y = '0, tot_xy = '0;
   logic [10:0]             idx_s;
   logic [RANK_W-1:0]       prev_rank_s;
   logic signed [X_W-1:0]   prev_x_s, prev_y_s;
   logic signed [XY_W-1:0]  prev_xy_s;
   logic [CNT_W-1:0]        cnt_tree [TREE_SLOTS];
   logic [63:0]             xs_tree [TREE_SLOTS];
   logic [63:0]             ys_tree [TREE_SLOTS];
   logic [63:0]             xys_tree [TREE_SLOTS];
   longint                  run_sum;

   sample_type pending_samples[$];
   longint  cross_sum_due[$];
   int      errors = 0;
   int      results_seen = 0;
   int      samples_sent = 0;
   int      sets_sent = 0;
   bit      quiet = 1'b0;
   int      long_hold_req = 0;
   int      long_hold_done = 0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   int      rsp_hold = 0;

   dyadic_tree_cross_sum_accumulator u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rank_y(drv.rank), .req_x(drv.x), .req_y(drv.y), .req_xy(drv.xy),
      .req_sx_x(drv.sx_x), .req_sx_y(drv.sx_y), .req_sx_xy(drv.sx_xy),
      .req_sy_x(drv.sy_x), .req_sy_y(drv.sy_y), .req_sy_xy(drv.sy_xy),
      .req_last(drv.last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cross_sum(rsp_cross_sum)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
   endtask

   function automatic longint sat64(wide_type v);
      if (&v[127:63] || ~|v[127:63]) return v[63:0];
      return v[127] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
   endfunction

   function automatic longint gamma_term(longint tree, longint total, longint v,
                                         longint sy, longint sx);
      wide_type g;
      g = wide_type'(tree) * 4 + wide_type'(total) - wide_type'(v) - wide_type'(sy) * 2
          - wide_type'(sx) * 2;
      return sat64(g);
   endfunction

   // Clear the per-set state
   function automatic void clear_set_state();
      idx_s = '0;
      prev_rank_s = '0;
      prev_x_s = '0;
      prev_y_s = '0;
      prev_xy_s = '0;
      run_sum = 0;
      for (int i = 0; i < TREE_SLOTS; i++) begin
         cnt_tree[i] = '0;
         xs_tree[i] = '0;
         ys_tree[i] = '0;
         xys_tree[i] = '0;
      end
   endfunction

   // Insert the previous sample, query lower ranks and fold the cross term
   function automatic void predict_cross_sum(sample_type s);
      logic [9:0] k;
      int unsigned off, pos, kk;
      longint cnt, tx, ty, txy, g1, gx, gy, gxy, xl, yl;
      wide_type acc;
      cnt = 0; tx = 0; ty = 0; txy = 0;
      if (idx_s != 0) begin
         off = 0;
         k = prev_rank_s - 1'b1;
         for (int lv = 0; lv < TREE_LEVELS; lv++) begin
            pos = off + (k >> lv);
            if (pos < TREE_SLOTS) begin
               cnt_tree[pos] = cnt_tree[pos] + 1'b1;
               xs_tree[pos] = xs_tree[pos] + longint'(prev_x_s);
               ys_tree[pos] = ys_tree[pos] + longint'(prev_y_s);
               xys_tree[pos] = xys_tree[pos] + longint'(prev_xy_s);
            end
            off += 1 << (TREE_LEVELS - lv);
         end
      end
      off = 0;
      k = s.rank - 1'b1;
      for (int lv = 0; lv < TREE_LEVELS; lv++) begin
         kk = k >> lv;
         if (kk[0]) begin
            pos = off + kk - 1;
            if (pos < TREE_SLOTS) begin
               cnt += cnt_tree[pos];
               tx += xs_tree[pos];
               ty += ys_tree[pos];
               txy += xys_tree[pos];
            end
         end
         off += 1 << (TREE_LEVELS - lv);
      end
      xl = s.x;
      yl = s.y;
      g1 = 4 * cnt + longint'({53'd0, n_reg}) - 1 - 2 * longint'({53'd0, s.rank})
           - 2 * (longint'({53'd0, idx_s}) + 1);
      gx = gamma_term(tx, tot_x, xl, s.sy_x, s.sx_x);
      gy = gamma_term(ty, tot_y, yl, s.sy_y, s.sx_y);
      gxy = gamma_term(txy, tot_xy, s.xy, s.sy_xy, s.sx_xy);
      acc = wide_type'(xl * yl) * wide_type'(g1) + wide_type'(gxy) * 65536
            - wide_type'(xl) * wide_type'(gy) - wide_type'(yl) * wide_type'(gx);
      run_sum = sat64(wide_type'(run_sum) + (acc >>> 16));
      prev_rank_s = s.rank;
      prev_x_s = s.x;
      prev_y_s = s.y;
      prev_xy_s = s.xy;
      idx_s = idx_s + 1'b1;
      if (s.last) begin
         cross_sum_due.push_back(run_sum);
         clear_set_state();
      end
   endfunction

   // Driver: offer queued samples, idle in random bursts
   always @(posedge clock) begin
      logic nv;
      nv = req_valid;
      if (!reset) begin
         if (req_valid && !req_stall) predict_cross_sum(drv);
         if (!req_valid || !req_stall) begin
            nv = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 5);
            end else if (pending_samples.size() > 0) begin
               drv <= pending_samples.pop_front();
               nv = 1'b1;
            end
         end
      end
      req_valid <= nv;
   end

   // Monitor: check results, stall in bursts and once for a long stretch
   always @(posedge clock) begin
      logic ns;
      longint want;
      ns = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (cross_sum_due.size() == 0) begin
               report($sformatf("unrequested cross_sum %0d", rsp_cross_sum));
            end else begin
               want = cross_sum_due.pop_front();
               if (rsp_cross_sum !== want)
                  report($sformatf("cross_sum got %0d want %0d", rsp_cross_sum, want));
            end
         end
         if (long_hold_req != long_hold_done) begin
            long_hold_done = long_hold_req;
            rsp_hold = 400;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            ns = 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            ns = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 5);
            ns = 1'b1;
         end
      end
      rsp_stall <= ns;
   end

   task automatic write_reg(input csr_index_type idx, input longint data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data[SUM_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ITEM_COUNT: n_reg = data[CNT_W-1:0];
         CSR_TOTAL_X:    tot_x = data[SUM_W-1:0];
         CSR_TOTAL_Y:    tot_y = data[SUM_W-1:0];
         CSR_TOTAL_XY:   tot_xy = data[SUM_W-1:0];
         default: ;
      endcase
   endtask

   // Hold until every sample is taken and every result is back, then settle
   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || cross_sum_due.size() != 0);
      repeat (150) @(posedge clock);
   endtask

   function automatic longint any48();
      case ($urandom_range(0, 3))
         0: return MAX48;
         1: return MIN48;
         default: return longint'({$urandom, $urandom});
      endcase
   endfunction

   function automatic sample_type noise_sample();
      logic [447:0] raw;
      sample_type s;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      s = raw[$bits(sample_type)-1:0];
      s.last = ($urandom_range(0, 3) == 0);
      return s;
   endfunction

   // Build a consistent set: rank permutation, products and running sums
   task automatic push_set(input int n, input bit full_range, input bit set_regs);
      sample_type s[$];
      int rk[];
      longint xv[], yv[], pv[];
      longint ax, ay, axy, bx, by, bxy;
      int j, t;
      rk = new[n]; xv = new[n]; yv = new[n]; pv = new[n];
      for (int i = 0; i < n; i++) rk[i] = i + 1;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = rk[i]; rk[i] = rk[j]; rk[j] = t;
      end
      for (int i = 0; i < n; i++) begin
         if (full_range) begin
            xv[i] = int'($urandom);
            yv[i] = int'($urandom);
         end else begin
            xv[i] = int'($urandom_range(0, 2000000)) - 1000000;
            yv[i] = int'($urandom_range(0, 2000000)) - 1000000;
         end
         pv[i] = (xv[i] * yv[i]) >>> 16;
      end
      ax = 0; ay = 0; axy = 0;
      for (int i = 0; i < n; i++) begin
         ax += xv[i]; ay += yv[i]; axy += pv[i];
         bx = 0; by = 0; bxy = 0;
         for (int m = 0; m < n; m++) begin
            if (rk[m] <= rk[i]) begin
               bx += xv[m]; by += yv[m]; bxy += pv[m];
            end
         end
         s.push_back({11'(rk[i]), 32'(xv[i]), 32'(yv[i]), 48'(pv[i]), 48'(ax), 48'(ay),
                      48'(axy), 48'(bx), 48'(by), 48'(bxy), i == n - 1});
      end
      if (set_regs) begin
         write_reg(CSR_ITEM_COUNT, longint'(n));
         write_reg(CSR_TOTAL_X, ax);
         write_reg(CSR_TOTAL_Y, ay);
         write_reg(CSR_TOTAL_XY, axy);
      end
      foreach (s[i]) pending_samples.push_back(s[i]);
      samples_sent += n;
      sets_sent++;
   endtask

   initial begin
      #5_000_000;
      $display("Timeout waiting for results");
      $display("Some tests failed");
      $finish;
   end

   initial begin
      sample_type s;
      clear_set_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Single-sample set with the reset configuration
      s = '0;
      s.rank = 11'd1;
      s.last = 1'b1;
      pending_samples.push_back(s);
      drain();

      // Field extremes, rank zero and out-of-range ranks, widest register values
      write_reg(CSR_ITEM_COUNT, 64'sd2047);
      write_reg(CSR_TOTAL_X, MAX48);
      write_reg(CSR_TOTAL_Y, MIN48);
      write_reg(CSR_TOTAL_XY, MAX48);
      s = {11'd0, 32'sh7FFFFFFF, 32'sh80000000, 48'(MAX48), 48'(MAX48), 48'(MIN48),
           48'(MAX48), 48'(MIN48), 48'(MAX48), 48'(MIN48), 1'b0};
      pending_samples.push_back(s);
      s = {11'h7FF, 32'sh80000000, 32'sh80000000, 48'(MIN48), 48'(MIN48), 48'(MIN48),
           48'(MIN48), 48'(MIN48), 48'(MIN48), 48'(MIN48), 1'b0};
      pending_samples.push_back(s);
      s = {11'd1024, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 48'(MAX48), 48'(MAX48), 48'(MAX48),
           48'(MAX48), 48'(MAX48), 48'(MAX48), 48'(MAX48), 1'b0};
      pending_samples.push_back(s);
      s.rank = 11'd1;
      s.last = 1'b1;
      pending_samples.push_back(s);
      drain();
      write_reg(CSR_ITEM_COUNT, 64'sd0);
      write_reg(CSR_TOTAL_X, MIN48);
      write_reg(CSR_TOTAL_Y, MAX48);
      write_reg(CSR_TOTAL_XY, MIN48);
      for (int i = 0; i < 6; i++) pending_samples.push_back(noise_sample());
      s = noise_sample();
      s.last = 1'b1;
      pending_samples.push_back(s);
      drain();
      push_set(8, 1'b1, 1'b1);
      drain();
      samples_sent += 12;

      // Fill the block while results are held back
      push_set(3, 1'b0, 1'b1);
      long_hold_req++;
      for (int i = 0; i < 5; i++) push_set($urandom_range(1, 4), 1'b0, 1'b0);
      drain();

      // Random sets, mostly consistent, some noise, a few large
      while (samples_sent < 920) begin
         if (samples_sent > 780) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0, 1: begin
               write_reg(CSR_ITEM_COUNT, longint'($urandom_range(0, 2047)));
               write_reg(CSR_TOTAL_X, any48());
               write_reg(CSR_TOTAL_Y, any48());
               write_reg(CSR_TOTAL_XY, any48());
               t_noise: for (int i = $urandom_range(1, 8); i > 0; i--) begin
                  pending_samples.push_back(noise_sample());
                  samples_sent++;
               end
            end
            2: push_set(($urandom_range(0, 15) == 0) ? $urandom_range(100, 200)
                        : $urandom_range(1, 16), 1'b1, 1'b1);
            default: push_set($urandom_range(1, 16), 1'b0, 1'b1);
         endcase
         drain();
      end
      // Close any open set so its result is checked
      s = noise_sample();
      s.last = 1'b1;
      pending_samples.push_back(s);
      drain();

      $display("Covered %0d samples in %0d consistent sets plus noise, %0d results checked",
               samples_sent, sets_sent, results_seen);
      $display("Register extremes, rank wrap, saturation and long output stalls exercised");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dtcsa_pkg.sv
rtl/core/dtcsa_front.sv
rtl/core/dtcsa_fifo.sv
rtl/core/dtcsa_back.sv
rtl/core/dyadic_tree_cross_sum_accumulator.sv
bench/tb_dyadic_tree_cross_sum_accumulator.sv
